[src/rle_pkg.sv]
// Shared types and constants for the RGB565 run-length decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package rle_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic check;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic run_zero;
		logic remain_last;
		logic out_free;
	} dp_status_t;

	// Configuration register indexes
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// 255*f/31 and 255*f/63 as one multiply by a scaled reciprocal, then a shift.
	// Scale 2^20 keeps the error below the smallest fractional step of the quotient.
	localparam int unsigned       RECIP_SHIFT = 20;
	localparam logic [23:0]       RB_RECIP    = 24'd8625630; // 255 * ceil(2^20 / 31)
	localparam logic [23:0]       G_RECIP     = 24'd4244475; // 255 * ceil(2^20 / 63)

	localparam int unsigned COLOR_W = 16;
	localparam int unsigned RUN_W   = 7;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned COUNT_W = 32;

endpackage

[src/rle_ctrl.sv]
// Controller state machine of the RGB565 run-length decoder.
// Depends on rle_pkg for the state type and the command and status structs.
module rle_ctrl
	import rle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				// drop empty runs without leaving idle
				if (in_valid && !status.run_zero) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free && status.remain_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd.load  = 1'b0;
		cmd.check = 1'b0;
		cmd.emit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[src/rle_datapath.sv]
// Datapath of the RGB565 run-length decoder: colour widening, run counter,
// pixel count, image size and the output register. Depends on rle_pkg.
module rle_datapath
	import rle_pkg::*;
#(
	parameter int unsigned MAX_RUN = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	input  logic [COLOR_W-1:0]   color565,
	input  logic [RUN_W-1:0]     run_length,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic [7:0]           red8,
	output logic [7:0]           green8,
	output logic [7:0]           blue8,
	output logic                 run_last,
	output logic                 image_end,
	output logic                 out_valid,
	input  logic                 out_ready
);

	localparam logic [RUN_W-1:0] MaxRunW = RUN_W'(MAX_RUN);

	logic [CFG_W-1:0]     width_q;
	logic [CFG_W-1:0]     height_q;
	logic [COUNT_W-1:0]   size_q;
	logic [COUNT_W-1:0]   pixel_count_q;
	logic [COUNT_W:0]     total_q;
	logic                 ends_q;
	logic [RUN_W-1:0]     remain_q;
	logic [7:0]           red_q;
	logic [7:0]           green_q;
	logic [7:0]           blue_q;
	logic                 out_valid_q;
	logic [7:0]           red_out_q;
	logic [7:0]           green_out_q;
	logic [7:0]           blue_out_q;
	logic                 last_out_q;
	logic                 end_out_q;

	logic [RUN_W-1:0]     run_sat;
	logic [28:0]          red_prod;
	logic [28:0]          green_prod;
	logic [28:0]          blue_prod;
	logic                 ends_now;

	assign run_sat = (run_length > MaxRunW) ? MaxRunW : run_length;

	assign red_prod   = 29'(color565[15:11]) * 29'(RB_RECIP);
	assign green_prod = 29'(color565[10:5])  * 29'(G_RECIP);
	assign blue_prod  = 29'(color565[4:0])   * 29'(RB_RECIP);

	assign ends_now = (total_q >= {1'b0, size_q});

	assign status.run_zero    = (run_length == '0);
	assign status.remain_last = (remain_q == RUN_W'(1));
	assign status.out_free    = !out_valid_q || out_ready;

	// configuration registers and the registered image size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
			size_q   <= COUNT_W'(1);
		end else begin
			if (cfg_we && cfg_index == REG_IMAGE_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_IMAGE_HEIGHT) begin
				height_q <= cfg_data;
			end
			size_q <= COUNT_W'(width_q) * COUNT_W'(height_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= '0;
			ends_q        <= 1'b0;
			remain_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				remain_q <= run_sat;
			end else if (cmd.emit) begin
				remain_q <= remain_q - RUN_W'(1);
			end
			if (cmd.check) begin
				ends_q        <= ends_now;
				pixel_count_q <= ends_now ? '0 : total_q[COUNT_W-1:0];
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			red_q   <= red_prod[RECIP_SHIFT+7:RECIP_SHIFT];
			green_q <= green_prod[RECIP_SHIFT+7:RECIP_SHIFT];
			blue_q  <= blue_prod[RECIP_SHIFT+7:RECIP_SHIFT];
			total_q <= {1'b0, pixel_count_q} + (COUNT_W+1)'(run_sat);
		end
		if (cmd.emit) begin
			red_out_q   <= red_q;
			green_out_q <= green_q;
			blue_out_q  <= blue_q;
			last_out_q  <= status.remain_last;
			end_out_q   <= status.remain_last && ends_q;
		end
	end

	assign red8      = red_out_q;
	assign green8    = green_out_q;
	assign blue8     = blue_out_q;
	assign run_last  = last_out_q;
	assign image_end = end_out_q;
	assign out_valid = out_valid_q;

endmodule

[src/rle_rgb565_to_rgb888_decoder_core.sv]
// Top level of the RGB565 run-length decoder: stream ports, controller and datapath.
// Depends on rle_pkg, rle_ctrl and rle_datapath.
//
// Usage:
//   Slave stream: one request per run, colour565 in s_tdata[15:0] and the run
//   length in s_tdata[22:16]. Runs longer than MAX_RUN are cut to MAX_RUN;
//   a run of zero is taken and emits nothing.
//   Master stream: one request per pixel, RGB888 in m_tdata, m_tlast on the
//   last pixel of a run, m_tuser on the pixel that completes the image.
//   Config channel: cfg_index 0 writes the image width, 1 the height; always
//   ready. Write only while the block is idle.
// Run handling:
//   After a run is taken, the check state and then the emit state put its first
//   pixel into the output register when that register is free; then one pixel
//   per cycle while m_tready stays high. A run holds the slave side while the
//   block takes the request, checks the pixel count against the image size in
//   the check state and sends each pixel from the emit state. The next run is
//   taken while the previous run's last pixel still waits in the output register.
// Reset clears the pixel count and the output valid flag; width and height return
// to 1. When m_tready is low the output register holds and the run counter waits.
module rle_rgb565_to_rgb888_decoder_core
	import rle_pkg::*;
#(
	parameter int unsigned MAX_RUN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // color565[15:0], run_length[22:16], zero[23]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // red8[7:0], green8[15:8], blue8[23:16]
	output logic        m_tlast,   // run_last
	output logic        m_tuser,   // image_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic [7:0] red8;
	logic [7:0] green8;
	logic [7:0] blue8;

	assign cfg_ready = 1'b1;

	rle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rle_datapath #(
		.MAX_RUN (MAX_RUN)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.color565   (s_tdata[15:0]),
		.run_length (s_tdata[22:16]),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.red8       (red8),
		.green8     (green8),
		.blue8      (blue8),
		.run_last   (m_tlast),
		.image_end  (m_tuser),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready)
	);

	assign m_tdata = {blue8, green8, red8};

	// An empty run leaves the block ready for the next request
	a_zero_run_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[22:16] == 7'd0 |=> s_tready)
		else $error("empty run left the idle state");

	// A non-empty run holds the slave side while it is expanded
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[22:16] != 7'd0 |=> !s_tready)
		else $error("run taken without leaving idle");

	// Image end only on the last pixel of a run
	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("image end flagged inside a run");

endmodule
